// ===== rtl/evad_pkg.sv =====
package evad_pkg;

   // frame accumulator: the sum saturates at 2^31-1, so 31 bits hold it
   localparam int SUM_W = 31;
   // frame length field, wide enough for the largest supported frame limit
   localparam int FCNT_W = 13;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [30:0] ROOT_START = 31'h4000_0000;
   localparam logic [15:0] HANG_SCALE = 16'd100;
   localparam logic [3:0] TOP_SHIFT = 4'd15;
   localparam int MIN_DRIFT_SHIFT = 6;

   localparam logic [5:0] SPM_RESET = 6'd8;
   localparam logic REG_SAMPLES_PER_MS = 1'b0;

   typedef struct packed {
      logic [SUM_W-1:0] sum;
      logic [FCNT_W-1:0] len;
   } frame_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ROOT,
      BK_EXTREMES,
      BK_LEVEL,
      BK_COMMIT
   } back_state_type;

endpackage

// ===== rtl/evad_front.sv =====
module evad_front
   import evad_pkg::*;
#(
   parameter int MAX_FRAME = 1024,
   parameter int SQUARE_SHIFT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   input  logic [15:0] in_sample,
   input  logic in_last,
   output logic in_ready,
   input  logic [QCNT_W-1:0] q_count,
   output logic push,
   output frame_type push_data
);

   localparam int CNT_W = $clog2(MAX_FRAME + 1);
   localparam int TERM_W = 31 - SQUARE_SHIFT;
   localparam logic [31:0] ROUND = 32'd1 << (SQUARE_SHIFT - 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME);

   logic a_valid_ff, a_valid_in;
   logic a_last_ff, a_last_in;
   logic [TERM_W-1:0] a_term_ff, a_term_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [15:0] sample_s;
   logic signed [31:0] square_s;
   logic [31:0] rounded;
   logic [31:0] sum_add;
   logic [SUM_W-1:0] sum_sat;
   logic [CNT_W-1:0] cnt_inc;
   logic accept;

   // hold off while a frame still in stage A could find the queue full
   assign in_ready = (QCNT_W'(q_count + QCNT_W'(a_valid_ff & a_last_ff))) < QCNT_W'(QUEUE_DEPTH);
   assign accept = in_valid & in_ready;

   assign sample_s = signed'(in_sample);
   assign square_s = sample_s * sample_s;
   assign rounded = (unsigned'(square_s) + ROUND) >> SQUARE_SHIFT;

   assign sum_add = {1'b0, sum_ff} + 32'(a_term_ff);
   assign sum_sat = sum_add[31] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
   assign cnt_inc = (cnt_ff < CNT_MAX) ? cnt_ff + 1'b1 : cnt_ff;

   assign push = a_valid_ff & a_last_ff;
   assign push_data.sum = sum_sat;
   assign push_data.len = FCNT_W'(cnt_inc);

   always_comb begin
      a_valid_in = accept;
      a_last_in = accept & in_last;
      a_term_in = rounded[TERM_W-1:0];
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (a_valid_ff) begin
         if (a_last_ff) begin
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_sat;
            cnt_in = cnt_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         a_last_ff <= 1'b0;
         sum_ff <= '0;
         cnt_ff <= '0;
      end else begin
         a_valid_ff <= a_valid_in;
         a_last_ff <= a_last_in;
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_term_ff <= a_term_in;
   end

endmodule

// ===== rtl/evad_queue.sv =====
module evad_queue
   import evad_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  frame_type push_data,
   input  logic pop,
   output frame_type pop_data,
   output logic [QCNT_W-1:0] count
);

   frame_type entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign pop_data = entry_ff[rd_ptr_ff];
   assign count = count_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10: count_in = count_ff + 1'b1;
         2'b01: count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/evad_back.sv =====
module evad_back
   import evad_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic [5:0] samples_per_ms,
   input  logic [QCNT_W-1:0] q_count,
   input  frame_type q_data,
   output logic pop,
   output logic out_valid,
   input  logic out_ready,
   output logic out_voiced,
   output logic [15:0] out_energy,
   output logic [15:0] out_silent
);

   back_state_type state_ff, state_in;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [30:0] bit_ff, bit_in;
   logic [FCNT_W-1:0] len_ff, len_in;
   logic [3:0] shift_ff, shift_in;

   logic seen_ff, seen_in;
   logic [15:0] max_ff, max_in;
   logic [15:0] min_ff, min_in;
   logic [15:0] step_ff, step_in;
   logic [15:0] first_ff, first_in;
   logic [15:0] hang_ff, hang_in;
   logic [15:0] silent_ff, silent_in;

   logic out_valid_ff, out_valid_in;
   logic out_voiced_ff, out_voiced_in;
   logic [15:0] out_energy_ff, out_energy_in;

   logic [31:0] trial;
   logic [15:0] cur;
   logic [15:0] gap;
   logic [3:0] gap_log;
   logic [16:0] thresh;
   logic [15:0] reload;
   logic [15:0] step_next;
   logic out_free;
   logic above;

   assign cur = root_ff[15:0];
   assign trial = root_ff + 32'(bit_ff);
   assign gap = max_ff - min_ff;
   assign thresh = {1'b0, max_ff >> shift_ff} + {1'b0, min_ff >> (TOP_SHIFT - shift_ff)};
   assign above = {1'b0, cur} > thresh;
   assign reload = 16'(samples_per_ms) * HANG_SCALE;
   assign step_next = step_ff + (min_ff >> MIN_DRIFT_SHIFT);
   assign out_free = !out_valid_ff || out_ready;

   // floor of log2 of the gap; zero and one both give zero
   always_comb begin
      gap_log = '0;
      for (int i = 1; i < 16; i++) begin
         if (gap[i]) begin
            gap_log = 4'(i);
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      pop = 1'b0;
      rem_in = rem_ff;
      root_in = root_ff;
      bit_in = bit_ff;
      len_in = len_ff;
      shift_in = shift_ff;
      seen_in = seen_ff;
      max_in = max_ff;
      min_in = min_ff;
      step_in = step_ff;
      first_in = first_ff;
      hang_in = hang_ff;
      silent_in = silent_ff;
      out_valid_in = out_valid_ff & !out_ready;
      out_voiced_in = out_voiced_ff;
      out_energy_in = out_energy_ff;

      case (state_ff)
         BK_IDLE: begin
            if (q_count != '0) begin
               pop = 1'b1;
               rem_in = 32'(q_data.sum);
               root_in = '0;
               bit_in = ROOT_START;
               len_in = q_data.len;
               state_in = BK_ROOT;
            end
         end
         BK_ROOT: begin
            if (trial <= rem_ff) begin
               rem_in = rem_ff - trial;
               root_in = (root_ff >> 1) + 32'(bit_ff);
            end else begin
               root_in = root_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff == 31'd1) begin
               state_in = BK_EXTREMES;
            end
         end
         BK_EXTREMES: begin
            if (!seen_ff) begin
               seen_in = 1'b1;
               max_in = cur;
               min_in = cur;
               first_in = cur;
            end else begin
               if (cur > max_ff) begin
                  max_in = cur;
               end
               if (cur < min_ff) begin
                  min_in = (cur == 16'd0) ? first_ff : cur;
               end
            end
            state_in = BK_LEVEL;
         end
         BK_LEVEL: begin
            shift_in = gap_log;
            state_in = BK_COMMIT;
         end
         BK_COMMIT: begin
            // hold the frame until the output register is free
            if (out_free) begin
               if (above) begin
                  out_voiced_in = 1'b1;
                  hang_in = reload;
               end else if (hang_ff < 16'(len_ff)) begin
                  out_voiced_in = 1'b0;
                  hang_in = '0;
                  silent_in = silent_ff + 1'b1;
               end else begin
                  out_voiced_in = 1'b1;
                  hang_in = hang_ff - 16'(len_ff);
               end
               step_in = step_next;
               min_in = min_ff + step_next;
               out_valid_in = 1'b1;
               out_energy_in = cur;
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         max_ff <= '0;
         min_ff <= '0;
         step_ff <= 16'd1;
         first_ff <= '0;
         hang_ff <= '0;
         silent_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         max_ff <= max_in;
         min_ff <= min_in;
         step_ff <= step_in;
         first_ff <= first_in;
         hang_ff <= hang_in;
         silent_ff <= silent_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      root_ff <= root_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      shift_ff <= shift_in;
      out_voiced_ff <= out_voiced_in;
      out_energy_ff <= out_energy_in;
   end

   assign out_valid = out_valid_ff;
   assign out_voiced = out_voiced_ff;
   assign out_energy = out_energy_ff;
   assign out_silent = silent_ff;

endmodule

// ===== rtl/energy_voice_activity_detector.sv =====
// Channel   Ports                    Moves
// -------   ----------------------   ------------------------------------------
// input     req_t* (valid/ready)     one audio sample request, tlast ends frame
// result    rsp_t* (valid/ready)     one result per frame: voiced, energy, count
// config    csr_p* (APB, 32 bit)     samples_per_ms at byte address 0
//
// The front takes one sample a cycle unless stalled: a multiply stage, then the
// saturating accumulate. Each frame end queues its sum in a two-entry queue.
// The back works on one frame at a time: a pop, 16 square root iterations
// (one result bit each), then extremes, gap log and decision states.
// Samples stall only when the queue, counting a frame about to be pushed,
// would be full. A stalled result holds the back.
// Reset is synchronous; there is no clearing pass.
module energy_voice_activity_detector
   import evad_pkg::*;
#(
   parameter int MAX_FRAME = 1024,
   parameter int SQUARE_SHIFT = 8
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,    // [15:0] sample
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [31:0] rsp_tdata,    // [15:0] frame_energy, [31:16] silence_frames
   output logic rsp_tuser,           // [0] voiced
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [2:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic csr_pready
);

   logic [5:0] spm_ff, spm_in;
   logic csr_write;

   logic [QCNT_W-1:0] q_count;
   logic push;
   logic pop;
   frame_type push_data;
   frame_type pop_data;
   logic [15:0] energy;
   logic [15:0] silent;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel & csr_penable & csr_pwrite & csr_pready
                      & (csr_paddr[2] == REG_SAMPLES_PER_MS);
   assign csr_prdata = (csr_paddr[2] == REG_SAMPLES_PER_MS) ? 32'(spm_ff) : 32'd0;
   assign spm_in = csr_write ? csr_pwdata[5:0] : spm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spm_ff <= SPM_RESET;
      end else begin
         spm_ff <= spm_in;
      end
   end

   evad_front #(
      .MAX_FRAME(MAX_FRAME),
      .SQUARE_SHIFT(SQUARE_SHIFT)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_sample(req_tdata),
      .in_last(req_tlast),
      .in_ready(req_tready),
      .q_count(q_count),
      .push(push),
      .push_data(push_data)
   );

   evad_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .pop(pop),
      .pop_data(pop_data),
      .count(q_count)
   );

   evad_back u_back (
      .clock(clock),
      .reset(reset),
      .samples_per_ms(spm_ff),
      .q_count(q_count),
      .q_data(pop_data),
      .pop(pop),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_voiced(rsp_tuser),
      .out_energy(energy),
      .out_silent(silent)
   );

   assign rsp_tdata = {silent, energy};

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= QCNT_W'(QUEUE_DEPTH))
      else $error("frame queue holds more entries than its depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
      else $error("frame pushed into a full queue");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !req_tready)
      else $error("sample request taken while the frame queue is full");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> (q_count != '0))
      else $error("frame popped from an empty queue");

endmodule
